// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Partition fit allocator package
// Shared widths, request and mode codes, configuration register indexes and
// the structures that travel along the row of segment cells.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Field widths of the request and result items.
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned SEG_IDX_W  = 4;
  localparam int unsigned AMOUNT_W   = 16;
  localparam int unsigned LEFT_OUT_W = 16;

  // Configuration register widths.
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // Default sizing of the segment table.
  localparam int unsigned DEF_MAX_SEGMENTS = 16;
  localparam int unsigned DEF_SIZE_WIDTH   = 16;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  // Selection policies; the unused code behaves as first fit.
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'd1;
  localparam logic [COUNT_W-1:0]   COUNT_RESET   = 5'd16;

  // Search probe moving from cell to cell.
  typedef struct packed {
    logic valid;
    logic found;
  } probe_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic load;
    logic clear;
    logic mark;
  } cell_cmd_t;

endpackage

// ===== rtl/pfa_cell.sv =====
// ----------------------------------------------------------------------------
// Partition fit allocator segment cell
// Holds one segment size and its used mark, and refines the search record
// of a passing probe before handing it to the next cell.
// ----------------------------------------------------------------------------
module pfa_cell import pfa_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int unsigned SIZE_WIDTH   = DEF_SIZE_WIDTH,
  parameter int unsigned IDX          = 0,
  localparam int unsigned IDX_W       = $clog2(MAX_SEGMENTS),
  localparam int unsigned CW          = (SIZE_WIDTH > AMOUNT_W) ? SIZE_WIDTH : AMOUNT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_cmd_t             cmd,
  input  logic [SEG_IDX_W-1:0]  load_idx,
  input  logic [AMOUNT_W-1:0]   load_amount,
  input  logic [IDX_W-1:0]      mark_idx,
  input  logic [AMOUNT_W-1:0]   amount,
  input  logic [MODE_W-1:0]     fit_mode,
  input  logic [COUNT_W-1:0]    seg_count,
  input  probe_t                probe_in,
  input  logic [IDX_W-1:0]      idx_in,
  input  logic [CW-1:0]         left_in,
  output probe_t                probe_out,
  output logic [IDX_W-1:0]      idx_out,
  output logic [CW-1:0]         left_out
);

  logic [SIZE_WIDTH-1:0] size_r;
  logic                  used_r, used_nxt;
  probe_t                probe_r, probe_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic [CW-1:0]         size_ext, amount_ext, left;
  logic                  eligible, take;

  // Fit test and candidate comparison for this segment.
  always_comb begin
    size_ext   = CW'(size_r);
    amount_ext = CW'(amount);
    left       = size_ext - amount_ext;
    eligible   = probe_in.valid && (32'(seg_count) > 32'(IDX)) && !used_r &&
                 (size_ext >= amount_ext);
    take       = eligible && (!probe_in.found ||
                 ((fit_mode == FIT_BEST) && (left < left_in)) ||
                 ((fit_mode == FIT_WORST) && (left > left_in)));
    probe_nxt.valid = probe_in.valid;
    probe_nxt.found = probe_in.found || eligible;
    idx_nxt    = take ? IDX_W'(IDX) : idx_in;
    left_nxt   = take ? left : left_in;
  end

  // Used mark: release clears, a grant to this segment sets.
  always_comb begin
    used_nxt = used_r;
    if (cmd.clear) begin
      used_nxt = 1'b0;
    end else if (cmd.mark && (mark_idx == IDX_W'(IDX))) begin
      used_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      probe_r <= '0;
    end else begin
      used_r  <= used_nxt;
      probe_r <= probe_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(load_idx) == 32'(IDX))) begin
      size_r <= SIZE_WIDTH'(load_amount);
    end
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
  end

  assign probe_out = probe_r;
  assign idx_out   = idx_r;
  assign left_out  = left_r;

endmodule

// ===== rtl/partition_fit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Partition fit allocator
// Fixed-partition allocator with first, best and worst fit selection.
// ----------------------------------------------------------------------------
// Load and release-all requests give no result. An allocate request sends a
// search probe along a row of MAX_SEGMENTS cells, one cell per cycle; each
// cell holds one segment size and its used mark. The result at the end of
// the row is caught in the hold registers and moves to the output register
// once that is free; no request is taken until it has moved. The granted
// segment is marked used at the end of the search. Configuration may be
// written only while no request is in flight.
module partition_fit_allocator_top import pfa_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int unsigned SIZE_WIDTH   = DEF_SIZE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [3:0] seg_index, [19:4] amount
  input  logic [REQ_W-1:0]      in_tuser,   // [1:0] req_type
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [3:0] granted_index, [19:4] leftover
  output logic                  out_tuser,  // [0] granted
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW    = (SIZE_WIDTH > AMOUNT_W) ? SIZE_WIDTH : AMOUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [MODE_W-1:0]     fit_mode_r;
  logic [COUNT_W-1:0]    seg_count_r;
  logic                  launch_r;
  logic [AMOUNT_W-1:0]   amount_r;
  logic                  hold_found_r;
  logic [IDX_W-1:0]      hold_idx_r;
  logic [CW-1:0]         hold_left_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  granted_r;
  logic [SEG_IDX_W-1:0]  gidx_r;
  logic [LEFT_OUT_W-1:0] left_r;

  logic                  accept, is_alloc, out_load, end_valid;
  cell_cmd_t             cmd;
  logic [SEG_IDX_W-1:0]  in_seg_index;
  logic [AMOUNT_W-1:0]   in_amount;

  probe_t                chain_probe [MAX_SEGMENTS+1];
  logic [IDX_W-1:0]      chain_idx   [MAX_SEGMENTS+1];
  logic [CW-1:0]         chain_left  [MAX_SEGMENTS+1];

  assign in_seg_index = in_tdata[SEG_IDX_W-1:0];
  assign in_amount    = in_tdata[SEG_IDX_W +: AMOUNT_W];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_alloc  = accept && (in_tuser == REQ_ALLOC);
  assign end_valid = (state_r == ST_SCAN) && chain_probe[MAX_SEGMENTS].valid;
  assign out_load  = (state_r == ST_HOLD) && (!out_valid_r || out_tready);

  // Commands to the row: loads and release from requests, grant from the search.
  always_comb begin
    cmd.load  = accept && (in_tuser == REQ_LOAD);
    cmd.clear = accept && (in_tuser == REQ_RELEASE);
    cmd.mark  = end_valid && chain_probe[MAX_SEGMENTS].found;
  end

  // Probe entering the first cell.
  assign chain_probe[0] = '{valid: launch_r, found: 1'b0};
  assign chain_idx[0]   = '0;
  assign chain_left[0]  = '0;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    pfa_cell #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .SIZE_WIDTH   (SIZE_WIDTH),
      .IDX          (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .load_idx    (in_seg_index),
      .load_amount (in_amount),
      .mark_idx    (chain_idx[MAX_SEGMENTS]),
      .amount      (amount_r),
      .fit_mode    (fit_mode_r),
      .seg_count   (seg_count_r),
      .probe_in    (chain_probe[i]),
      .idx_in      (chain_idx[i]),
      .left_in     (chain_left[i]),
      .probe_out   (chain_probe[i+1]),
      .idx_out     (chain_idx[i+1]),
      .left_out    (chain_left[i+1])
    );
  end

  // Sequencing of one request at a time.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_alloc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (end_valid) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: filled from the hold stage, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fit_mode_r  <= FIT_FIRST;
      seg_count_r <= COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= is_alloc;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_MODE:  fit_mode_r  <= cfg_wdata[MODE_W-1:0];
          CFG_SEG_COUNT: seg_count_r <= cfg_wdata[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Request amount, search result and output payload.
  always_ff @(posedge clk) begin
    if (is_alloc) begin
      amount_r <= in_amount;
    end
    if (end_valid) begin
      hold_found_r <= chain_probe[MAX_SEGMENTS].found;
      hold_idx_r   <= chain_idx[MAX_SEGMENTS];
      hold_left_r  <= chain_left[MAX_SEGMENTS];
    end
    if (out_load) begin
      granted_r <= hold_found_r;
      gidx_r    <= SEG_IDX_W'(hold_idx_r);
      left_r    <= LEFT_OUT_W'(hold_left_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = granted_r;
  assign out_tdata  = {4'd0, left_r, gidx_r};

endmodule

// ===== test/tb_partition_fit_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition fit allocator testbench
// Runs a short list of directed requests, then phases of random load,
// allocate and release-all requests under changing fit modes and segment
// counts. Every grant is checked against a local model of the segment table
// or, for directed rows that state one, a known expected grant.
module tb_partition_fit_allocator_top;
  import pfa_pkg::*;

  localparam int MAX_SEG         = DEF_MAX_SEGMENTS;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int DRAIN_CYCLES    = 24;
  localparam int HOLD_AT         = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 500000;

  // Codes the package leaves unnamed: the spare request kind and fit mode.
  localparam logic [REQ_W-1:0]  REQ_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0] FIT_SPARE  = 2'd3;

  typedef struct packed {
    logic                  granted;
    logic [SEG_IDX_W-1:0]  index;
    logic [LEFT_OUT_W-1:0] leftover;
  } grant_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [REQ_W-1:0]      kind;
    logic [SEG_IDX_W-1:0]  idx;
    logic [AMOUNT_W-1:0]   amount;
    logic [MODE_W-1:0]     mode;
    logic [COUNT_W-1:0]    count;
    logic                  typed;
    grant_t                want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;   // [3:0] seg_index, [19:4] amount
  logic [REQ_W-1:0]      in_tuser;   // [1:0] req_type
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;  // [3:0] granted_index, [19:4] leftover
  logic                  out_tuser;  // [0] granted
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Local copy of the segment table and the configuration.
  logic [AMOUNT_W-1:0] seg_size [MAX_SEG];
  bit                  seg_used [MAX_SEG];
  logic [MODE_W-1:0]   fit_sel;
  logic [COUNT_W-1:0]  seg_limit;

  grant_t   grant_queue[$];
  dir_row_t directed_rows[$];
  int       mismatch_count;
  int       grants_seen;
  int       cycle_count;
  bit       fast_sender;
  bit       fast_receiver;

  partition_fit_allocator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Chooses a segment for an allocate request and marks it used.
  function automatic grant_t allocate_segment(logic [AMOUNT_W-1:0] amount);
    grant_t              g;
    int                  limit;
    bit                  found;
    int                  pick;
    logic [AMOUNT_W-1:0] left;
    logic [AMOUNT_W-1:0] best_left;
    g         = '0;
    found     = 1'b0;
    pick      = 0;
    best_left = '0;
    limit     = (int'(seg_limit) > MAX_SEG) ? MAX_SEG : int'(seg_limit);
    for (int j = 0; j < limit; j++) begin
      if (!seg_used[j] && seg_size[j] >= amount) begin
        left = seg_size[j] - amount;
        if (!found) begin
          found     = 1'b1;
          pick      = j;
          best_left = left;
          // First fit, and the spare mode, stop at the first candidate.
          if (fit_sel != FIT_BEST && fit_sel != FIT_WORST) break;
        end else if (fit_sel == FIT_BEST && left < best_left) begin
          pick      = j;
          best_left = left;
        end else if (fit_sel == FIT_WORST && left > best_left) begin
          pick      = j;
          best_left = left;
        end
      end
    end
    if (found) begin
      seg_used[pick] = 1'b1;
      g = '{granted: 1'b1, index: SEG_IDX_W'(pick), leftover: best_left};
    end
    return g;
  endfunction

  // Draws an amount, often close to a stored size so that fits are tight.
  function automatic logic [AMOUNT_W-1:0] draw_amount(bit near_size);
    logic [AMOUNT_W-1:0] base;
    int                  sel;
    base = seg_size[$urandom_range(0, MAX_SEG - 1)];
    sel  = $urandom_range(0, 9);
    if (near_size && sel < 3) return base;
    if (near_size && sel < 5) return base - AMOUNT_W'($urandom_range(0, 3));
    case (sel)
      5:       return '0;
      6:       return '1;
      7, 8:    return AMOUNT_W'($urandom);
      default: return AMOUNT_W'($urandom_range(0, 8) * 250);
    endcase
  endfunction

  function automatic dir_row_t item_row(logic [REQ_W-1:0] kind, logic [SEG_IDX_W-1:0] idx,
                                        logic [AMOUNT_W-1:0] amount);
    dir_row_t r;
    r        = '0;
    r.kind   = kind;
    r.idx    = idx;
    r.amount = amount;
    return r;
  endfunction

  function automatic dir_row_t known_row(logic [AMOUNT_W-1:0] amount, logic granted,
                                         logic [SEG_IDX_W-1:0] index,
                                         logic [LEFT_OUT_W-1:0] leftover);
    dir_row_t r;
    r       = item_row(REQ_ALLOC, '0, amount);
    r.typed = 1'b1;
    r.want  = '{granted: granted, index: index, leftover: leftover};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.mode   = mode;
    r.count  = count;
    return r;
  endfunction

  // Offers one request after a random gap and updates the model on acceptance.
  task automatic send_request(logic [REQ_W-1:0] kind, logic [SEG_IDX_W-1:0] idx,
                              logic [AMOUNT_W-1:0] amount, bit typed, grant_t want);
    int     gap;
    grant_t got;
    gap = fast_sender ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, amount, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (kind)
      REQ_LOAD:    seg_size[idx] = amount;
      REQ_RELEASE: foreach (seg_used[j]) seg_used[j] = 1'b0;
      REQ_ALLOC: begin
        got = allocate_segment(amount);
        grant_queue.push_back(typed ? want : got);
      end
      default: ;
    endcase
  endtask

  // Stops offering and waits until no grant is outstanding and the block settles.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the fit mode register and then the segment count register; only called while idle.
  task automatic configure(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIT_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_SEG_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    fit_sel   = mode;
    seg_limit = count;
  endtask

  // Compares one accepted grant with the oldest expectation.
  task automatic check_grant(grant_t got);
    grant_t want;
    if (grant_queue.size() == 0) begin
      $display("%0t: grant with none expected: granted=%0d index=%0d leftover=%0d",
               $time, got.granted, got.index, got.leftover);
      mismatch_count++;
    end else begin
      want = grant_queue.pop_front();
      if (got.granted !== want.granted) begin
        $display("%0t: granted expected %0d, got %0d", $time, want.granted, got.granted);
        mismatch_count++;
      end
      if (got.index !== want.index) begin
        $display("%0t: granted_index expected %0d, got %0d", $time, want.index, got.index);
        mismatch_count++;
      end
      if (got.leftover !== want.leftover) begin
        $display("%0t: leftover expected %0d, got %0d", $time, want.leftover,
                 got.leftover);
        mismatch_count++;
      end
    end
  endtask

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (grants_seen == HOLD_AT) stall = HOLD_CYCLES;
      else if (fast_receiver) stall = 0;
      else stall = $urandom_range(0, 13);
      if ($urandom_range(0, 39) == 0) fast_receiver = !fast_receiver;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      grants_seen++;
      check_grant({out_tuser, out_tdata[3:0], out_tdata[19:4]});
    end
  end

  // Request side: reset, directed list, table fill, then random phases.
  initial begin
    int                  pick;
    int                  real_items;
    logic [MODE_W-1:0]   mode;
    logic [COUNT_W-1:0]  count;
    dir_row_t            row;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_LOAD;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FIT_MODE;
    cfg_wdata <= '0;
    fit_sel   = FIT_FIRST;
    seg_limit = COUNT_RESET;
    foreach (seg_used[j]) begin
      seg_used[j] = 1'b0;
      seg_size[j] = '0;
    end

    // With a segment count of zero every allocate is refused; the spare kind is ignored.
    directed_rows.push_back(cfg_row(FIT_FIRST, 5'd0));
    directed_rows.push_back(known_row(16'd0, 1'b0, 4'd0, 16'd0));
    directed_rows.push_back(item_row(REQ_SPARE, 4'hF, 16'hFFFF));
    // Four segments with extreme sizes.
    directed_rows.push_back(item_row(REQ_LOAD, 4'd0, 16'd100));
    directed_rows.push_back(item_row(REQ_LOAD, 4'd1, 16'hFFFF));
    directed_rows.push_back(item_row(REQ_LOAD, 4'd2, 16'd40));
    directed_rows.push_back(item_row(REQ_LOAD, 4'd3, 16'd0));
    // First fit walks the segments in order until all are used.
    directed_rows.push_back(cfg_row(FIT_FIRST, 5'd4));
    directed_rows.push_back(known_row(16'd40, 1'b1, 4'd0, 16'd60));
    directed_rows.push_back(known_row(16'hFFFF, 1'b1, 4'd1, 16'd0));
    directed_rows.push_back(known_row(16'd0, 1'b1, 4'd2, 16'd40));
    directed_rows.push_back(known_row(16'd0, 1'b1, 4'd3, 16'd0));
    directed_rows.push_back(known_row(16'd0, 1'b0, 4'd0, 16'd0));
    directed_rows.push_back(item_row(REQ_RELEASE, 4'd0, 16'd0));
    // Best, worst and the spare mode after a release.
    directed_rows.push_back(cfg_row(FIT_BEST, 5'd4));
    directed_rows.push_back(item_row(REQ_ALLOC, 4'd0, 16'd30));
    directed_rows.push_back(item_row(REQ_ALLOC, 4'd0, 16'd0));
    directed_rows.push_back(cfg_row(FIT_WORST, 5'd4));
    directed_rows.push_back(item_row(REQ_ALLOC, 4'd0, 16'd1));
    directed_rows.push_back(item_row(REQ_RELEASE, 4'hF, 16'hFFFF));
    directed_rows.push_back(cfg_row(FIT_SPARE, 5'd4));
    directed_rows.push_back(item_row(REQ_ALLOC, 4'd0, 16'd1));
    directed_rows.push_back(item_row(REQ_RELEASE, 4'd0, 16'd0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        configure(row.mode, row.count);
      end else begin
        send_request(row.kind, row.idx, row.amount, row.typed, row.want);
      end
    end

    // Every size entry gets written before any wider search can read it.
    for (int j = 0; j < MAX_SEG; j++)
      send_request(REQ_LOAD, SEG_IDX_W'(j), draw_amount(1'b0), 1'b0, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       begin mode = FIT_FIRST; count = 5'd16; end
        1:       begin mode = FIT_BEST;  count = 5'd16; end
        2:       begin mode = FIT_WORST; count = 5'd16; end
        3:       begin mode = FIT_SPARE; count = 5'd16; end
        4:       begin mode = FIT_BEST;  count = 5'd1;  end
        5:       begin mode = FIT_WORST; count = 5'd31; end
        6:       begin mode = FIT_FIRST; count = 5'd0;  end
        7:       begin mode = FIT_BEST;  count = 5'd17; end
        8:       begin mode = FIT_WORST; count = 5'd5;  end
        default: begin
          mode  = MODE_W'($urandom_range(0, 3));
          count = COUNT_W'($urandom_range(0, 31));
        end
      endcase
      configure(mode, count);
      fast_sender = (phase % 3 == 2);
      real_items  = 0;
      while (real_items < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_request(REQ_LOAD, SEG_IDX_W'($urandom_range(0, 15)), draw_amount(1'b0),
                       1'b0, '0);
          real_items++;
        end else if (pick < 80) begin
          send_request(REQ_ALLOC, SEG_IDX_W'($urandom_range(0, 15)), draw_amount(1'b1),
                       1'b0, '0);
          real_items++;
        end else if (pick < 92) begin
          send_request(REQ_RELEASE, SEG_IDX_W'($urandom_range(0, 15)),
                       AMOUNT_W'($urandom), 1'b0, '0);
          real_items++;
        end else begin
          send_request(REQ_SPARE, SEG_IDX_W'($urandom_range(0, 15)),
                       AMOUNT_W'($urandom), 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0 && grant_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfa_pkg.sv
rtl/pfa_cell.sv
rtl/partition_fit_allocator_top.sv
test/tb_partition_fit_allocator_top.sv
